### hw/rtl/aavr_pkg.sv
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared types, constants and arithmetic helpers for the axis-angle rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package aavr_pkg;

    localparam int unsigned CORDIC_STEPS = 20;
    localparam int unsigned CORDIC_PER_STAGE = 2;
    localparam int unsigned CORDIC_STAGES = CORDIC_STEPS / CORDIC_PER_STAGE;

    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;

    localparam logic signed [63:0] MAX64 = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] MIN64 = {1'b1, {63{1'b0}}};
    localparam logic signed [31:0] MAX32 = {1'b0, {31{1'b1}}};
    localparam logic signed [31:0] MIN32 = {1'b1, {31{1'b0}}};

    // CORDIC working state: Q4.30 x/y, angle residue in 2^32-per-turn units
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
        logic [1:0]         quad;
    } cordic_t;

    // arctangent of 2^-i in 2^32-per-turn units
    function automatic logic signed [32:0] atan_turns(input int unsigned i);
        logic signed [32:0] r;
        begin
            unique case (i)
                0:  r = 33'sh020000000;
                1:  r = 33'sh012E4051E;
                2:  r = 33'sh009FB385B;
                3:  r = 33'sh0051111D4;
                4:  r = 33'sh0028B0D43;
                5:  r = 33'sh00145D7E1;
                6:  r = 33'sh000A2F61E;
                7:  r = 33'sh000517C55;
                8:  r = 33'sh00028BE53;
                9:  r = 33'sh000145F2F;
                10: r = 33'sh0000A2F98;
                11: r = 33'sh0000517CC;
                12: r = 33'sh000028BE6;
                13: r = 33'sh0000145F3;
                14: r = 33'sh00000A2FA;
                15: r = 33'sh00000517D;
                16: r = 33'sh0000028BE;
                17: r = 33'sh00000145F;
                18: r = 33'sh000000A30;
                19: r = 33'sh000000518;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // one rotation-mode micro-rotation, arithmetic (floor) shifts
    function automatic cordic_t cordic_step(input cordic_t p, input int unsigned i);
        cordic_t r;
        begin
            r = p;
            if (!p.z[32]) begin
                r.x = p.x - (p.y >>> i);
                r.y = p.y + (p.x >>> i);
                r.z = p.z - atan_turns(i);
            end
            else begin
                r.x = p.x + (p.y >>> i);
                r.y = p.y - (p.x >>> i);
                r.z = p.z + atan_turns(i);
            end
            return r;
        end
    endfunction

    // shift right toward zero, then saturate to signed 64 bits
    function automatic logic signed [63:0] shr_sat(input logic signed [97:0] p,
                                                   input int unsigned sh);
        logic signed [97:0] bias;
        logic signed [97:0] q;
        begin
            bias = p[97] ? ((98'sd1 <<< sh) - 98'sd1) : '0;
            q    = (p + bias) >>> sh;
            if (q[97:63] != {35{q[97]}})
                return q[97] ? MIN64 : MAX64;
            return q[63:0];
        end
    endfunction

    // saturating 64-bit add
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        begin
            s = 65'(a) + 65'(b);
            if (s[64] != s[63])
                return s[64] ? MIN64 : MAX64;
            return s[63:0];
        end
    endfunction

    // saturate 64 bits down to 32
    function automatic logic signed [31:0] clamp32(input logic signed [63:0] a);
        begin
            if (a[63:31] != {33{a[63]}})
                return a[63] ? MIN32 : MAX32;
            return a[31:0];
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/aavr_mul.sv
// ----------------------------------------------------------------------------
// aavr_mul
// Two-stage signed 64 x 34 multiplier built from two partial products (33x34, 32x34).
// ----------------------------------------------------------------------------
`default_nettype none

module aavr_mul (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [63:0] a,
    input  wire logic signed [33:0] b,
    output logic signed [97:0]      p
);
    import aavr_pkg::*;

    logic signed [66:0] lo_reg, lo_next;
    logic signed [65:0] hi_reg, hi_next;
    logic signed [97:0] p_reg, p_next;

    // partial products: unsigned low word and signed high word
    always_comb
    begin
        lo_next = 67'($signed({1'b0, a[31:0]})) * 67'(b);
        hi_next = 66'($signed(a[63:32])) * 66'(b);
        p_next  = (98'(hi_reg) <<< 32) + 98'(lo_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

### hw/rtl/aavr_cordic.sv
// ----------------------------------------------------------------------------
// aavr_cordic
// Pipelined 20-step CORDIC sine/cosine, two steps per stage, plus quadrant
// fold and clamp to [-1, 1] in Q2.30, registered at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module aavr_cordic (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [15:0]        angle,
    output logic signed [31:0]      cos_q,
    output logic signed [31:0]      sin_q
);
    import aavr_pkg::*;

    cordic_t            st_reg  [1:CORDIC_STAGES];
    cordic_t            st_next [1:CORDIC_STAGES];
    cordic_t            init;
    logic signed [34:0] c_raw, s_raw;
    logic signed [31:0] c_reg, c_next, s_reg, s_next;

    // start vector (K, 0), residue of the quadrant
    always_comb
    begin
        init.x    = CORDIC_K;
        init.y    = '0;
        init.z    = $signed({3'b000, angle[13:0], 16'h0000});
        init.quad = angle[15:14];
    end

    // micro-rotation stages
    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_stage
        if (g == 0)
        begin : g_first
            always_comb
            begin
                st_next[1] = cordic_step(cordic_step(init, 0), 1);
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                st_next[g+1] = cordic_step(
                    cordic_step(st_reg[g], CORDIC_PER_STAGE * g),
                    CORDIC_PER_STAGE * g + 1);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[g+1] <= st_next[g+1];
        end
    end

    // quadrant fold and clamp
    always_comb
    begin
        unique case (st_reg[CORDIC_STAGES].quad)
            2'd0:
            begin
                c_raw = 35'(st_reg[CORDIC_STAGES].x);
                s_raw = 35'(st_reg[CORDIC_STAGES].y);
            end
            2'd1:
            begin
                c_raw = -35'(st_reg[CORDIC_STAGES].y);
                s_raw = 35'(st_reg[CORDIC_STAGES].x);
            end
            2'd2:
            begin
                c_raw = -35'(st_reg[CORDIC_STAGES].x);
                s_raw = -35'(st_reg[CORDIC_STAGES].y);
            end
            default:
            begin
                c_raw = 35'(st_reg[CORDIC_STAGES].y);
                s_raw = -35'(st_reg[CORDIC_STAGES].x);
            end
        endcase

        if (c_raw > 35'(ONE_Q30))
            c_next = 32'(ONE_Q30);
        else if (c_raw < -35'(ONE_Q30))
            c_next = -32'(ONE_Q30);
        else
            c_next = c_raw[31:0];

        if (s_raw > 35'(ONE_Q30))
            s_next = 32'(ONE_Q30);
        else if (s_raw < -35'(ONE_Q30))
            s_next = -32'(ONE_Q30);
        else
            s_next = s_raw[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= c_next;
            s_reg <= s_next;
        end
    end

    assign cos_q = c_reg;
    assign sin_q = s_reg;

endmodule

`default_nettype wire

### hw/rtl/axis_angle_vector_rotation.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation
// Rotates a Q16.16 vector about a (unit) axis by a binary angle using the
// axis-angle rotation matrix; null vector or axis gives zero and a flag.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while no result is held; the pipeline has 21
// stages (input, CORDIC stages, then matrix build and matrix-vector product through
// split multipliers). A held result stalls the whole pipeline in the same cycle.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none

module axis_angle_vector_rotation (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic signed [31:0] vec_x,
    input  wire logic signed [31:0] vec_y,
    input  wire logic signed [31:0] vec_z,
    input  wire logic signed [31:0] axis_x,
    input  wire logic signed [31:0] axis_y,
    input  wire logic signed [31:0] axis_z,
    input  wire logic [15:0]        turn_angle,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic                    null_error
);
    import aavr_pkg::*;

    localparam int unsigned LAST = 20;

    logic                adv;
    logic [LAST:0]       valid_reg;

    logic signed [31:0]  vec_reg  [0:15][0:2];
    logic signed [31:0]  axis_reg [0:11][0:2];
    logic                null_reg [0:19];
    logic [15:0]         angle_reg;

    logic signed [31:0]  cos_q, sin_q;

    logic signed [63:0]  pp_reg [0:5];
    logic signed [63:0]  sa_reg [0:2];
    logic signed [33:0]  t_reg;
    logic signed [31:0]  c_reg [12:14];
    logic signed [63:0]  sk_reg [13:14][0:2];
    logic signed [97:0]  tp [0:5];
    logic signed [63:0]  tt [0:5];
    logic signed [63:0]  m_reg [0:2][0:2];
    logic signed [63:0]  m_next [0:2][0:2];
    logic signed [97:0]  prod [0:2][0:2];
    logic signed [63:0]  term_reg [0:2][0:2];
    logic signed [63:0]  acc_reg [0:2];
    logic signed [63:0]  t2_reg [0:2];
    logic signed [31:0]  res_next [0:2];
    logic signed [31:0]  res_reg [0:2];

    // pipeline advances unless a finished result is held
    assign adv        = !(valid_reg[LAST] && result_stall);
    assign item_stall = !adv;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[LAST-1:0], item_valid};
    end

    // input stage and delay lines
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_reg[0][0]  <= vec_x;
            vec_reg[0][1]  <= vec_y;
            vec_reg[0][2]  <= vec_z;
            axis_reg[0][0] <= axis_x;
            axis_reg[0][1] <= axis_y;
            axis_reg[0][2] <= axis_z;
            angle_reg      <= turn_angle;
            null_reg[0]    <= (vec_x == '0 && vec_y == '0 && vec_z == '0) ||
                              (axis_x == '0 && axis_y == '0 && axis_z == '0);
            for (int k = 1; k <= 15; k++)
                vec_reg[k] <= vec_reg[k-1];
            for (int k = 1; k <= 11; k++)
                axis_reg[k] <= axis_reg[k-1];
            for (int k = 1; k <= 19; k++)
                null_reg[k] <= null_reg[k-1];
        end
    end

    // sine and cosine, stages 1..11
    aavr_cordic u_cordic (
        .clk   (clk),
        .en    (adv),
        .angle (angle_reg),
        .cos_q (cos_q),
        .sin_q (sin_q)
    );

    // stage 12: axis products, sine terms, 1 - cos
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_reg[0] <= 64'(axis_reg[11][0]) * 64'(axis_reg[11][0]);
            pp_reg[1] <= 64'(axis_reg[11][1]) * 64'(axis_reg[11][1]);
            pp_reg[2] <= 64'(axis_reg[11][2]) * 64'(axis_reg[11][2]);
            pp_reg[3] <= 64'(axis_reg[11][0]) * 64'(axis_reg[11][1]);
            pp_reg[4] <= 64'(axis_reg[11][0]) * 64'(axis_reg[11][2]);
            pp_reg[5] <= 64'(axis_reg[11][1]) * 64'(axis_reg[11][2]);
            for (int k = 0; k < 3; k++)
                sa_reg[k] <= 64'(sin_q) * 64'(axis_reg[11][k]);
            t_reg     <= ONE_Q30 - 34'(cos_q);
            c_reg[12] <= cos_q;
        end
    end

    // stages 13..14: (1 - cos) * a_i * a_j, sine terms scaled
    for (genvar k = 0; k < 6; k++)
    begin : g_tmul
        aavr_mul u_tmul (
            .clk (clk),
            .en  (adv),
            .a   (pp_reg[k]),
            .b   (t_reg),
            .p   (tp[k])
        );
        assign tt[k] = shr_sat(tp[k], 32);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sk_reg[13][k] <= shr_sat(98'(sa_reg[k]), 16);
                sk_reg[14][k] <= sk_reg[13][k];
            end
            c_reg[13] <= c_reg[12];
            c_reg[14] <= c_reg[13];
        end
    end

    // stage 15: rotation matrix
    always_comb
    begin
        m_next[0][0] = sat_add64(tt[0], 64'(c_reg[14]));
        m_next[1][1] = sat_add64(tt[1], 64'(c_reg[14]));
        m_next[2][2] = sat_add64(tt[2], 64'(c_reg[14]));
        m_next[0][1] = sat_add64(tt[3], -sk_reg[14][2]);
        m_next[1][0] = sat_add64(tt[3], sk_reg[14][2]);
        m_next[0][2] = sat_add64(tt[4], sk_reg[14][1]);
        m_next[2][0] = sat_add64(tt[4], -sk_reg[14][1]);
        m_next[1][2] = sat_add64(tt[5], -sk_reg[14][0]);
        m_next[2][1] = sat_add64(tt[5], sk_reg[14][0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            m_reg <= m_next;
    end

    // stages 16..17: matrix times vector, one split multiplier per entry
    for (genvar i = 0; i < 3; i++)
    begin : g_row
        for (genvar j = 0; j < 3; j++)
        begin : g_col
            aavr_mul u_vmul (
                .clk (clk),
                .en  (adv),
                .a   (m_reg[i][j]),
                .b   (34'(vec_reg[15][j])),
                .p   (prod[i][j])
            );
        end
    end

    // stage 18: scale back to Q16.16; stage 19: first sum; stage 20: result
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            res_next[i] = null_reg[19] ? '0 : clamp32(sat_add64(acc_reg[i], t2_reg[i]));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    term_reg[i][j] <= shr_sat(prod[i][j], 30);
                acc_reg[i] <= sat_add64(term_reg[i][0], term_reg[i][1]);
                t2_reg[i]  <= term_reg[i][2];
                res_reg[i] <= res_next[i];
            end
            null_error <= null_reg[19];
        end
    end

    assign result_valid = valid_reg[LAST];
    assign out_x        = res_reg[0];
    assign out_y        = res_reg[1];
    assign out_z        = res_reg[2];

endmodule

`default_nettype wire
